/* sv/assert_macros.svh */
// Assertion macros used by the allocator top level.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked property check with reset disable.
`define FPBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpba assertion failed");
// Condition that must never hold outside reset.
`define FPBA_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fpba forbidden condition seen");
`else
`define FPBA_ASSERT(lbl, clk, rst_n, prop)
`define FPBA_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* sv/fpba_pkg.sv */
// Shared types, constants and helpers of the fit-policy block allocator.
// No dependencies; used by fpba_cell and the top level.
package fpba_pkg;

    localparam int NUM_BLOCKS = 8;
    localparam int SIZE_W     = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BLK_W      = 3;
    localparam int AMT_W      = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int POL_W      = 2;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    // word index of a register on the configuration port
    localparam logic REG_FIT_POLICY = 1'b0;

    typedef struct packed {
        logic             action;
        logic [BLK_W-1:0] block_number;
        logic [AMT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic             granted;
        logic [BLK_W-1:0] chosen_block;
    } out_item_t;

    // search wave handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SIZE_W-1:0] cap;
        logic [IDX_W-1:0]  idx;
    } wave_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic [POL_W-1:0]  policy;
        logic [SIZE_W-1:0] amount;
        logic              commit_en;
        logic [IDX_W-1:0]  commit_idx;
    } cell_ctrl_t;

    // amount field taken modulo 2^SIZE_W
    function automatic logic [SIZE_W-1:0] to_size(input logic [AMT_W-1:0] a);
        logic [AMT_W+SIZE_W-1:0] w;
        w = (AMT_W + SIZE_W)'(a);
        return w[SIZE_W-1:0];
    endfunction

    // block index masked to the result field width
    function automatic logic [BLK_W-1:0] to_blk(input logic [IDX_W-1:0] i);
        logic [31:0] w;
        w = 32'(i);
        return w[BLK_W-1:0];
    endfunction

endpackage

/* sv/fpba_cell.sv */
// One allocator cell: holds a block's remaining capacity and judges the
// passing search wave against it. Depends on fpba_pkg.
module fpba_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [fpba_pkg::IDX_W-1:0]    cell_idx,
    input  fpba_pkg::cell_ctrl_t          ctrl,
    input  logic                          load_en,
    input  logic [fpba_pkg::SIZE_W-1:0]   load_value,
    input  fpba_pkg::wave_t               wave_in,
    output fpba_pkg::wave_t               wave_out
);
    import fpba_pkg::*;

    logic [SIZE_W-1:0] cap_reg, cap_next;
    wave_t             wave_reg, wave_next;
    logic              fits, better, take;

    always_comb begin
        if (load_en) begin
            cap_next = load_value;
        end else if (ctrl.commit_en && ctrl.commit_idx == cell_idx) begin
            cap_next = cap_reg - ctrl.amount;
        end else begin
            cap_next = cap_reg;
        end
    end

    always_comb begin
        fits = cap_reg >= ctrl.amount;
        case (ctrl.policy)
            POL_BEST:  better = cap_reg < wave_in.cap;
            POL_WORST: better = cap_reg > wave_in.cap;
            default:   better = 1'b0;  // first fit keeps the earliest candidate
        endcase
        take = wave_in.valid && fits && (!wave_in.found || better);

        wave_next.valid = wave_in.valid;
        wave_next.found = wave_in.found || take;
        wave_next.cap   = take ? cap_reg : wave_in.cap;
        wave_next.idx   = take ? cell_idx : wave_in.idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= '0;
            wave_reg <= '0;
        end else begin
            cap_reg  <= cap_next;
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;

endmodule

/* sv/fit_policy_block_allocator.sv */
// Top level of the fit-policy block allocator: cell chain, control and APB port.
// Depends on fpba_pkg, fpba_cell and assert_macros.svh.
//
// Keeps the remaining capacity of NUM_BLOCKS blocks in a row of cells, one
// block per cell. A load transaction writes the capacity of one block, and the
// allocator is ready again on the next cycle. An allocate transaction sends a
// search wave down the cell row, one cell per cycle; each cell replaces the
// held candidate if its block fits and wins under fit_policy (0 first, 1 best,
// 2 worst fit, 3 as first fit). The result is registered once the wave leaves
// the last cell, and no new transaction is taken before it is in the output
// register or in ST_HOLD. A result in the output register may wait on m_ready
// while loads and a new allocation are taken; a second result then waits in
// ST_HOLD, and nothing is taken until it moves out. Capacities clear at reset.
// fit_policy sits at APB byte address 0.
`include "assert_macros.svh"

module fit_policy_block_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fpba_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fpba_pkg::out_item_t             m_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpba_pkg::PADDR_W-1:0]    paddr,
    input  logic [fpba_pkg::PDATA_W-1:0]    pwdata,
    output logic [fpba_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import fpba_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic              start_reg, start_next;
    logic [SIZE_W-1:0] amt_reg, amt_next;
    logic [POL_W-1:0]  policy_reg, policy_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;
    out_item_t         res_reg, res_next;

    logic              s_accept, cfg_write, out_free, done;
    out_item_t         scan_res;
    cell_ctrl_t        ctrl;
    logic [SIZE_W-1:0] load_value;
    logic [NUM_BLOCKS-1:0] load_sel;
    wave_t             chain [NUM_BLOCKS+1];

    assign s_ready   = state_reg == ST_IDLE;
    assign s_accept  = s_valid && s_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_FIT_POLICY) ? PDATA_W'(policy_reg) : '0;

    assign load_value = to_size(s_item.amount);

    assign chain[0] = '{valid: start_reg, found: 1'b0, cap: '0, idx: '0};

    assign done     = chain[NUM_BLOCKS].valid;
    assign out_free = !m_valid_reg || m_ready;
    assign scan_res.granted      = chain[NUM_BLOCKS].found;
    assign scan_res.chosen_block = chain[NUM_BLOCKS].found ?
                                   to_blk(chain[NUM_BLOCKS].idx) : '0;

    assign ctrl.policy     = policy_reg;
    assign ctrl.amount     = amt_reg;
    assign ctrl.commit_en  = done && chain[NUM_BLOCKS].found;
    assign ctrl.commit_idx = chain[NUM_BLOCKS].idx;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_BLOCKS; gi++) begin : g_cell
            assign load_sel[gi] = s_accept && s_item.action == ACT_LOAD &&
                                  32'(s_item.block_number) == 32'(gi);

            fpba_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cell_idx   (IDX_W'(gi)),
                .ctrl       (ctrl),
                .load_en    (load_sel[gi]),
                .load_value (load_value),
                .wave_in    (chain[gi]),
                .wave_out   (chain[gi+1])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        start_next   = 1'b0;
        amt_next     = amt_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        policy_next  = policy_reg;

        if (cfg_write && paddr[2] == REG_FIT_POLICY) begin
            policy_next = pwdata[POL_W-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_item.action == ACT_ALLOC) begin
                    amt_next   = to_size(s_item.amount);
                    start_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (done) begin
                    if (out_free) begin
                        m_item_next  = scan_res;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        res_next   = scan_res;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            policy_reg  <= POL_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            policy_reg  <= policy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        amt_reg    <= amt_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // the wave only leaves the last cell while the search is under way
    `FPBA_ASSERT(a_exit_in_scan, aclk, aresetn, done |-> state_reg == ST_SCAN)
    // a held result exists only because the output register is occupied
    `FPBA_ASSERT(a_hold_busy, aclk, aresetn, state_reg == ST_HOLD |-> m_valid_reg)
    // a refused allocation reports block zero
    `FPBA_NEVER(a_deny_zero, aclk, aresetn, m_valid_reg && !m_item_reg.granted && m_item_reg.chosen_block != '0)
    // no load lands while a search is moving through the cells
    `FPBA_NEVER(a_no_load_in_scan, aclk, aresetn, (load_sel != '0) && state_reg != ST_IDLE)

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of fit_policy_block_allocator: drives load and allocate
// transactions and APB writes of fit_policy, and checks grants against a predictor.
// Depends on fpba_pkg and the allocator RTL only.
module testbench;
    import fpba_pkg::*;

    // policy code with no name of its own; it behaves as first fit
    localparam logic [POL_W-1:0] POL_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = NUM_BLOCKS + 6;
    localparam int PHASE_ITEMS = 300;

    // Predicts the grant of each allocation and checks results in order.
    class alloc_scoreboard;
        logic [SIZE_W-1:0] capacity [NUM_BLOCKS];
        logic [POL_W-1:0] policy;
        out_item_t pending_grants[$];
        int errors;

        function new();
            foreach (capacity[i]) capacity[i] = '0;
            policy = POL_FIRST;
            errors = 0;
        endfunction

        function void note_item(in_item_t it);
            logic [SIZE_W-1:0] need;
            bit found;
            int pick;
            out_item_t res;
            need = it.amount;
            if (it.action == ACT_LOAD) begin
                if (it.block_number < NUM_BLOCKS) capacity[it.block_number] = need;
                return;
            end
            found = 0;
            pick = 0;
            for (int j = 0; j < NUM_BLOCKS; j++) begin
                if (capacity[j] >= need) begin
                    if (!found) begin
                        found = 1;
                        pick = j;
                    end else if ((policy == POL_BEST && capacity[j] < capacity[pick]) ||
                                 (policy == POL_WORST && capacity[j] > capacity[pick])) begin
                        pick = j;
                    end
                end
            end
            res.granted = found;
            res.chosen_block = found ? BLK_W'(pick) : '0;
            if (found) capacity[pick] = capacity[pick] - need;
            pending_grants.push_back(res);
        endfunction

        function void check_grant(out_item_t got);
            out_item_t want;
            if (pending_grants.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: granted=%0d chosen_block=%0d",
                             got.granted, got.chosen_block);
                return;
            end
            want = pending_grants.pop_front();
            if (got.granted !== want.granted || got.chosen_block !== want.chosen_block) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected granted=%0d chosen_block=%0d, got %0d %0d",
                             want.granted, want.chosen_block, got.granted, got.chosen_block);
            end
        endfunction

        function int outstanding();
            return pending_grants.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    alloc_scoreboard model = new();
    int items_sent = 0;
    bit quiet = 0;

    fit_policy_block_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t mk(logic act, logic [BLK_W-1:0] blk, logic [AMT_W-1:0] amt);
        in_item_t it;
        it.action = act;
        it.block_number = blk;
        it.amount = amt;
        return it;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int r;
        it.block_number = BLK_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 35) begin
            it.action = ACT_LOAD;
            it.amount = (r < 18) ? AMT_W'($urandom_range(0, 65535))
                                 : AMT_W'($urandom_range(0, 255));
        end else begin
            it.action = ACT_ALLOC;
            r = $urandom_range(0, 99);
            if (r < 50) it.amount = AMT_W'($urandom_range(0, 63));
            else if (r < 75) it.amount = AMT_W'($urandom_range(0, 4095));
            else if (r < 90) it.amount = AMT_W'($urandom_range(0, 65535));
            // exact fit against a current capacity
            else if (r < 95) it.amount = model.capacity[$urandom_range(0, NUM_BLOCKS - 1)];
            else if (r < 97) it.amount = '0;
            else it.amount = '1;
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        model.note_item(it);
        items_sent++;
    endtask

    // drain all pending grants, then let any load still in flight finish
    task automatic settle();
        s_valid <= 1'b0;
        while (model.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_fit_policy(input logic [POL_W-1:0] p);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({REG_FIT_POLICY, 2'b00});
        pwdata <= PDATA_W'(p);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model.policy = p;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) model.check_grant(m_item);
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    initial begin
        int hold;
        int r;
        bit pressed;
        hold = 0;
        pressed = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!pressed && items_sent >= 400) begin
                pressed = 1;
                hold = 300;
            end else if (hold == 0 && !quiet) begin
                r = $urandom_range(0, 99);
                if (r < 15) hold = $urandom_range(1, 3);
                else if (r < 18) hold = $urandom_range(10, 40);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [POL_W-1:0] phase_policy [6];
        phase_policy = '{POL_BEST, POL_WORST, POL_SPARE, POL_FIRST, POL_WORST, POL_BEST};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store: zero request fits everywhere, anything else is refused
        send_item(mk(ACT_ALLOC, 3'd5, 16'd0));
        send_item(mk(ACT_ALLOC, 3'd2, 16'd1));
        send_item(mk(ACT_LOAD, 3'd0, 16'd100));
        send_item(mk(ACT_LOAD, 3'd1, 16'hFFFF));
        send_item(mk(ACT_LOAD, 3'd2, 16'd30));
        send_item(mk(ACT_LOAD, 3'd3, 16'd30));
        send_item(mk(ACT_LOAD, 3'd4, 16'd0));
        send_item(mk(ACT_LOAD, 3'd5, 16'd500));
        send_item(mk(ACT_LOAD, 3'd6, 16'hFFFF));
        send_item(mk(ACT_LOAD, 3'd7, 16'd1));
        send_item(mk(ACT_ALLOC, 3'd7, 16'hFFFF));
        send_item(mk(ACT_ALLOC, 3'd0, 16'd30));
        send_item(mk(ACT_ALLOC, 3'd0, 16'hFFFF));
        send_item(mk(ACT_ALLOC, 3'd0, 16'hFFFF));
        send_item(mk(ACT_ALLOC, 3'd0, 16'd0));
        settle();
        write_fit_policy(POL_BEST);
        send_item(mk(ACT_ALLOC, 3'd0, 16'd30));
        send_item(mk(ACT_ALLOC, 3'd0, 16'd1));
        send_item(mk(ACT_ALLOC, 3'd0, 16'd0));
        settle();
        write_fit_policy(POL_WORST);
        send_item(mk(ACT_ALLOC, 3'd0, 16'd10));
        send_item(mk(ACT_ALLOC, 3'd0, 16'd0));
        settle();
        write_fit_policy(POL_SPARE);
        send_item(mk(ACT_ALLOC, 3'd0, 16'd10));
        send_item(mk(ACT_ALLOC, 3'd0, 16'd600));

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_fit_policy(phase_policy[ph]);
            quiet = (ph == 3);
            repeat (PHASE_ITEMS) send_item(rand_item());
        end
        quiet = 0;
        settle();

        if (model.errors == 0 && model.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/fpba_pkg.sv
sv/fpba_cell.sv
sv/fit_policy_block_allocator.sv
tb/testbench.sv
